@@ hw/rtl/isfp_pkg.sv @@
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants for the serial IMU frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'h3A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  // Configuration defaults
  localparam logic [7:0] MAX_LENGTH_RESET    = 8'd80;
  localparam int         MAX_PAYLOAD_DEFAULT = 128;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MAX_LENGTH = 1'b0;

  // Result kinds
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  // Frame end status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_BAD_TAIL = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [15:0] dev_id;
    logic [15:0] command;
    logic [7:0]  length;
    status_t     status;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/isfp_if.sv @@
// ----------------------------------------------------------------------------
// isfp_if
// Valid/ready channels for received bytes and parser results.
// ----------------------------------------------------------------------------
interface isfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [6:0]  payload_index;
  logic [15:0] dev_id;
  logic [15:0] command;
  logic [7:0]  length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output dev_id, output command, output length, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input dev_id, input command, input length, input status,
                  input last, output ready);
endinterface

@@ hw/rtl/isfp_apb_regs.sv @@
// ----------------------------------------------------------------------------
// isfp_apb_regs
// APB-style configuration register file holding the payload length limit.
// ----------------------------------------------------------------------------
module isfp_apb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [isfp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [isfp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [isfp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [7:0]                      max_length
);
  import isfp_pkg::*;

  logic [7:0] max_length_r;
  logic [7:0] max_length_nxt;
  logic       reg_index;
  logic       wr_en;

  // Decode the word address
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Update the limit on a completed write
  always_comb begin
    max_length_nxt = max_length_r;
    if (wr_en && (reg_index == REG_MAX_LENGTH)) begin
      max_length_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else begin
      max_length_r <= max_length_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_index == REG_MAX_LENGTH) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, max_length_r};
    end
  end

  assign max_length = max_length_r;

endmodule

@@ hw/rtl/isfp_parser.sv @@
// ----------------------------------------------------------------------------
// isfp_parser
// Input byte register and frame state; one byte parsed per cycle while results are taken.
// ----------------------------------------------------------------------------
module isfp_parser #(
  parameter int MAX_PAYLOAD = isfp_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic [7:0]          max_length,
  output logic                res_valid,
  output isfp_pkg::result_t   res,
  input  logic                res_ready
);
  import isfp_pkg::*;

  // Position counts header (1..6), payload, checksum and tail bytes
  localparam int POS_NEED = $clog2(MAX_PAYLOAD + 11);
  localparam int POS_W    = (POS_NEED > 9) ? POS_NEED : 9;

  localparam logic [POS_W-1:0] P_IDLE   = POS_W'(0);
  localparam logic [POS_W-1:0] P_ID_LO  = POS_W'(1);
  localparam logic [POS_W-1:0] P_ID_HI  = POS_W'(2);
  localparam logic [POS_W-1:0] P_CMD_LO = POS_W'(3);
  localparam logic [POS_W-1:0] P_CMD_HI = POS_W'(4);
  localparam logic [POS_W-1:0] P_LEN_LO = POS_W'(5);
  localparam logic [POS_W-1:0] P_LEN_HI = POS_W'(6);
  localparam logic [POS_W-1:0] P_DATA   = POS_W'(7);
  localparam logic [7:0]       PAY_MAX  = 8'(MAX_PAYLOAD);

  logic             inb_valid_r, inb_valid_nxt;
  logic [7:0]       inb_byte_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      cmd_r, cmd_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      rsum_r, rsum_nxt;
  logic             cr_r, cr_nxt;

  logic             adv;
  logic [POS_W-1:0] off;
  logic [POS_W-1:0] len_ext;
  logic [7:0]       limit;
  logic             too_long;
  logic [7:0]       b;

  // Input register: take a byte when empty or whenever the held one moves on
  assign adv      = inb_valid_r && res_ready;
  assign in_ready = !inb_valid_r || adv;
  assign b        = inb_byte_r;

  always_comb begin
    inb_valid_nxt = inb_valid_r;
    if (in_ready) begin
      inb_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inb_byte_r <= in_byte;
    end
  end

  // Length check against the smaller of register and build limit
  assign limit    = (max_length < PAY_MAX) ? max_length : PAY_MAX;
  assign too_long = (b != 8'h00) || (len_r > limit);
  assign off      = pos_r - P_DATA;
  assign len_ext  = POS_W'(len_r);

  // Parse the held byte
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    cmd_nxt   = cmd_r;
    sum_nxt   = sum_r;
    rsum_nxt  = rsum_r;
    cr_nxt    = cr_r;
    res_valid = 1'b0;
    res       = '0;
    res.dev_id  = id_r;
    res.command = cmd_r;
    res.length  = len_r;

    if (adv) begin
      if (pos_r == P_IDLE) begin
        // Hunt for a start byte, drop everything else
        if (b == START_BYTE) begin
          pos_nxt  = P_ID_LO;
          len_nxt  = '0;
          id_nxt   = '0;
          cmd_nxt  = '0;
          sum_nxt  = '0;
          rsum_nxt = '0;
          cr_nxt   = 1'b0;
        end
      end else if (pos_r <= P_LEN_HI) begin
        // Header bytes
        sum_nxt = sum_r + 16'(b);
        pos_nxt = pos_r + P_ID_LO;
        case (pos_r)
          P_ID_LO:  id_nxt  = {8'h00, b};
          P_ID_HI:  id_nxt  = {b, id_r[7:0]};
          P_CMD_LO: cmd_nxt = {8'h00, b};
          P_CMD_HI: cmd_nxt = {b, cmd_r[7:0]};
          P_LEN_LO: len_nxt = b;
          P_LEN_HI: begin
            if (too_long) begin
              res_valid  = 1'b1;
              res.kind   = KIND_STATUS;
              res.length = (b != 8'h00) ? 8'hFF : len_r;
              res.status = ST_TOO_LONG;
              res.last   = 1'b1;
              pos_nxt    = P_IDLE;
            end
          end
          default: ;
        endcase
      end else if (off < len_ext) begin
        // Payload byte
        sum_nxt           = sum_r + 16'(b);
        pos_nxt           = pos_r + P_ID_LO;
        res_valid         = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = b;
        res.payload_index = off[6:0];
      end else if (off == len_ext) begin
        rsum_nxt = {8'h00, b};
        pos_nxt  = pos_r + P_ID_LO;
      end else if (off == len_ext + P_ID_LO) begin
        rsum_nxt = {b, rsum_r[7:0]};
        pos_nxt  = pos_r + P_ID_LO;
      end else if (off == len_ext + P_ID_HI) begin
        cr_nxt  = (b == CR_BYTE);
        pos_nxt = pos_r + P_ID_LO;
      end else begin
        // Tail byte: report frame status, bad tail wins over bad sum
        res_valid = 1'b1;
        res.kind  = KIND_STATUS;
        res.last  = 1'b1;
        if (!cr_r || (b != LF_BYTE)) begin
          res.status = ST_BAD_TAIL;
        end else if (sum_r != rsum_r) begin
          res.status = ST_BAD_SUM;
        end else begin
          res.status = ST_OK;
        end
        pos_nxt = P_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inb_valid_r <= 1'b0;
      pos_r       <= P_IDLE;
      len_r       <= '0;
      id_r        <= '0;
      cmd_r       <= '0;
      sum_r       <= '0;
      rsum_r      <= '0;
      cr_r        <= 1'b0;
    end else begin
      inb_valid_r <= inb_valid_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      id_r        <= id_nxt;
      cmd_r       <= cmd_nxt;
      sum_r       <= sum_nxt;
      rsum_r      <= rsum_nxt;
      cr_r        <= cr_nxt;
    end
  end

  // A frame end always sends the parser back to hunting
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last) |=> (pos_r == P_IDLE))
    else $error("parser did not return to idle after frame end");

  // Position stays inside the longest legal frame
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_PAYLOAD + 10))
    else $error("frame position out of range");

  // Past the header the stored length never exceeds the build limit
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r > P_LEN_HI) |-> (len_r <= PAY_MAX))
    else $error("accepted payload length above limit");

endmodule

@@ hw/rtl/isfp_out_skid.sv @@
// ----------------------------------------------------------------------------
// isfp_out_skid
// Two-entry result buffer with a registered ready toward the parser.
// ----------------------------------------------------------------------------
module isfp_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  isfp_pkg::result_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  output isfp_pkg::result_t out_data,
  input  logic              out_ready
);
  import isfp_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && !skid_valid_r;
  assign pop       = main_valid_r && out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Refill the output register from the skid entry first, then the input
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = in_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = in_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry only fills behind a held output item
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry holds an item while output is empty");

  // A stalled push lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_valid_r && !out_ready) |=> skid_valid_r)
    else $error("item lost on output stall");

endmodule

@@ hw/rtl/imu_serial_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_top
// Frames serial IMU packets one byte per item and reports payload and status.
// ----------------------------------------------------------------------------
// Path: a taken byte is held in the input register and parsed from there; its
//   result loads the output register, or the skid entry if the output stalls.
// Throughput: one byte per cycle, set by the frame state update, unless skid is full.
// Reset (rst_n low, synchronous): max_length returns to 80, the parser hunts
//   for a start byte and both buffers are empty.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_top #(
  parameter int MAX_PAYLOAD = isfp_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  isfp_in_if.sink                         in_if,
  isfp_out_if.source                      out_if,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [isfp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [isfp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [isfp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import isfp_pkg::*;

  logic    [7:0] max_length;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  // Configuration registers
  isfp_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .max_length (max_length)
  );

  // Frame parser
  isfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_byte    (in_if.rx_byte),
    .in_ready   (in_if.ready),
    .max_length (max_length),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output buffer
  isfp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (res_ready),
    .out_valid (out_if.valid),
    .out_data  (out_res),
    .out_ready (out_if.ready)
  );

  // Unpack the result item onto the channel
  assign out_if.kind          = out_res.kind;
  assign out_if.payload_byte  = out_res.payload_byte;
  assign out_if.payload_index = out_res.payload_index;
  assign out_if.dev_id        = out_res.dev_id;
  assign out_if.command       = out_res.command;
  assign out_if.length        = out_res.length;
  assign out_if.status        = out_res.status;
  assign out_if.last          = out_res.last;

endmodule
